// File: rtl/adv_pkg.sv
// Shared types and constants for the archive directory validator.
package adv_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_ENTRY,
    PH_BACKPTR,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK,
    ST_SMALL,
    ST_MAGIC,
    ST_COUNT,
    ST_DIROFF,
    ST_TILING,
    ST_LOW_OFFSET,
    ST_ORDER,
    ST_NAME,
    ST_BACKPTR,
    ST_LAST_OFFSET
  } status_t;

  typedef struct packed {
    logic [15:0] member_index;
    logic [30:0] member_offset;
    logic [31:0] member_size;
    logic        is_member;
    logic        is_final;
    status_t     status;
  } result_t;

  localparam int FILE_SIZE_W = 33;
  localparam int CNT_W       = 5;
  localparam int TILE_W      = 21;

  localparam logic [15:0]            MAGIC_VALUE = 16'h04D2;
  localparam logic [FILE_SIZE_W-1:0] MIN_FILE    = 33'd31;
  localparam logic [31:0]            HEADER_END  = 32'd8;
  localparam logic [31:0]            MIN_OFFSET  = 32'd8;
  localparam logic [30:0]            INIT_PREV   = 31'd7;
  localparam logic [TILE_W-1:0]      BACKPTR_LEN = 21'd4;

  localparam logic [CNT_W-1:0] POS_ZERO   = 5'd0;
  localparam logic [CNT_W-1:0] POS_MAGIC  = 5'd1;
  localparam logic [CNT_W-1:0] POS_COUNT  = 5'd3;
  localparam logic [CNT_W-1:0] POS_DIROFF = 5'd7;
  localparam logic [CNT_W-1:0] POS_OFFSET = 5'd3;
  localparam logic [CNT_W-1:0] NAME_FIRST = 5'd4;
  localparam logic [CNT_W-1:0] NAME_LAST  = 5'd17;
  localparam logic [CNT_W-1:0] POS_BPTR   = 5'd3;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7e;

endpackage

// File: rtl/adv_parse.sv
// Byte parser: header, directory entries and back-pointer checks.
module adv_parse
  import adv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [FILE_SIZE_W-1:0] file_size,
  input  logic                   take,
  input  logic [7:0]             data_byte,
  input  logic                   first,
  output logic                   res_valid,
  output result_t                res
);

  phase_t            phase, phase_next, ph_cur;
  logic [CNT_W-1:0]  cnt, cnt_next, cnt_cur;
  logic [15:0]       total, total_next;
  logic [TILE_W-1:0] tile, tile_next;
  logic [31:0]       dir, dir_next;
  logic [15:0]       idx, idx_next, idx_inc;
  logic [31:0]       wa, wa_next, wa_cur, wa_new;
  logic [30:0]       prev, prev_next;
  logic              pad, pad_next, bad, bad_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      total <= '0;
      tile  <= '0;
      dir   <= '0;
      idx   <= '0;
      wa    <= '0;
      prev  <= INIT_PREV;
      pad   <= 1'b0;
      bad   <= 1'b0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      total <= total_next;
      tile  <= tile_next;
      dir   <= dir_next;
      idx   <= idx_next;
      wa    <= wa_next;
      prev  <= prev_next;
      pad   <= pad_next;
      bad   <= bad_next;
    end
  end

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    total_next = total;
    tile_next  = tile;
    dir_next   = dir;
    idx_next   = idx;
    wa_next    = wa;
    prev_next  = prev;
    pad_next   = pad;
    bad_next   = bad;
    res_valid  = 1'b0;
    res        = '0;
    ph_cur     = first ? PH_HEADER : phase;
    cnt_cur    = first ? '0 : cnt;
    wa_cur     = first ? '0 : wa;
    wa_new     = {data_byte, wa_cur[31:8]};
    idx_inc    = idx + 16'd1;
    if (take) begin
      if (first) begin
        total_next = '0;
        dir_next   = '0;
        idx_next   = '0;
        prev_next  = INIT_PREV;
        pad_next   = 1'b0;
        bad_next   = 1'b0;
      end
      if (ph_cur == PH_HEADER || ph_cur == PH_ENTRY || ph_cur == PH_BACKPTR) begin
        wa_next    = wa_new;
        cnt_next   = cnt_cur + 5'd1;
        phase_next = ph_cur;
        case (ph_cur)
          PH_HEADER: begin
            case (cnt_cur)
              POS_ZERO: begin
                if (file_size < MIN_FILE) begin
                  phase_next   = PH_DONE;
                  res_valid    = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_SMALL;
                end
              end
              POS_MAGIC: begin
                if (wa_new[31:16] != MAGIC_VALUE) begin
                  phase_next   = PH_DONE;
                  res_valid    = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_MAGIC;
                end
              end
              POS_COUNT: begin
                total_next = wa_new[31:16];
                tile_next  = {1'b0, wa_new[31:16], 4'b0} + {4'b0, wa_new[31:16], 1'b0}
                             + BACKPTR_LEN;
                if (wa_new[31:16] == 16'd0) begin
                  phase_next   = PH_DONE;
                  res_valid    = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_COUNT;
                end
              end
              POS_DIROFF: begin
                dir_next = wa_new;
                if (wa_new <= HEADER_END) begin
                  phase_next   = PH_DONE;
                  res_valid    = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_DIROFF;
                end else if ({1'b0, wa_new} + {12'b0, tile} != file_size) begin
                  phase_next   = PH_DONE;
                  res_valid    = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_TILING;
                end else begin
                  phase_next = PH_ENTRY;
                  cnt_next   = '0;
                end
              end
              default: ;
            endcase
          end
          PH_ENTRY: begin
            if (cnt_cur == POS_OFFSET) begin
              if (wa_new[31] || wa_new < MIN_OFFSET) begin
                phase_next   = PH_DONE;
                res_valid    = 1'b1;
                res.is_final = 1'b1;
                res.status   = ST_LOW_OFFSET;
              end else if (wa_new[30:0] <= prev) begin
                phase_next   = PH_DONE;
                res_valid    = 1'b1;
                res.is_final = 1'b1;
                res.status   = ST_ORDER;
              end else begin
                prev_next = wa_new[30:0];
                if (idx != 16'd0) begin
                  res_valid         = 1'b1;
                  res.is_member     = 1'b1;
                  res.member_index  = idx - 16'd1;
                  res.member_offset = prev;
                  res.member_size   = wa_new - {1'b0, prev};
                end
              end
            end else if (cnt_cur >= NAME_FIRST) begin
              if (data_byte == 8'd0) begin
                if (cnt_cur == NAME_FIRST) begin
                  bad_next = 1'b1;
                end
                pad_next = 1'b1;
              end else if (pad || data_byte < PRINT_LO || data_byte > PRINT_HI) begin
                bad_next = 1'b1;
              end
              if (cnt_cur == NAME_LAST) begin
                if (bad_next) begin
                  phase_next   = PH_DONE;
                  res_valid    = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_NAME;
                end else begin
                  pad_next = 1'b0;
                  bad_next = 1'b0;
                  cnt_next = '0;
                  idx_next = idx_inc;
                  if (idx_inc >= total) begin
                    phase_next = PH_BACKPTR;
                  end
                end
              end
            end
          end
          PH_BACKPTR: begin
            if (cnt_cur == POS_BPTR) begin
              phase_next   = PH_DONE;
              res_valid    = 1'b1;
              res.is_final = 1'b1;
              if (wa_new != dir) begin
                res.status = ST_BACKPTR;
              end else if ({1'b0, prev} >= dir) begin
                res.status = ST_LAST_OFFSET;
              end else begin
                res.status        = ST_OK;
                res.is_member     = 1'b1;
                res.member_index  = total - 16'd1;
                res.member_offset = prev;
                res.member_size   = dir - {1'b0, prev};
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: rtl/archive_directory_validator.sv
// Top level: size register, byte parser and two-entry result buffer.
// A result is registered, in the skid register when the result register is held.
// Throughput: one byte per cycle; data_stall rises only while both the result
// register and the skid register hold results waiting on result_stall.
// Reset (rst, synchronous): clears file_size, the parse state and both buffers.
module archive_directory_validator
  import adv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write_enable,
  input  logic [FILE_SIZE_W-1:0] write_data,
  input  logic                   data_valid,
  output logic                   data_stall,
  input  logic [7:0]             data_byte,
  input  logic                   first,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [15:0]            member_index,
  output logic [30:0]            member_offset,
  output logic [31:0]            member_size,
  output logic                   is_member,
  output logic                   is_final,
  output logic [3:0]             status
);

  logic [FILE_SIZE_W-1:0] file_size;
  logic                   take;
  logic                   res_valid;
  result_t                res;
  result_t                out_res, skid_res;
  logic                   out_valid, skid_valid;
  logic                   out_fire;

  assign data_stall = skid_valid;
  assign take       = data_valid && !skid_valid;
  assign out_fire   = out_valid && !result_stall;

  adv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .file_size (file_size),
    .take      (take),
    .data_byte (data_byte),
    .first     (first),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= '0;
    end else if (write_enable) begin
      file_size <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_res   <= res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign result_valid  = out_valid;
  assign member_index  = out_res.member_index;
  assign member_offset = out_res.member_offset;
  assign member_size   = out_res.member_size;
  assign is_member     = out_res.is_member;
  assign is_final      = out_res.is_final;
  assign status        = out_res.status;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_fire) |=> (out_valid && !skid_valid))
    else $error("skid result lost on output transfer");

  a_member_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.is_member && out_res.is_final) |-> (out_res.status == ST_OK))
    else $error("last member reported with a failing verdict");

  a_no_member_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.is_member) |-> (out_res.member_size == 32'd0))
    else $error("member fields not cleared on a verdict-only result");

endmodule
